// ===== design/assert_macros.svh =====
// assertion helpers shared by the codec modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define UUC_ASSERT_ALWAYS(label, clock, resetn, expr) \
    label: assert property (@(posedge clock) disable iff (!resetn) (expr)) \
        else $error("uuc: invariant violated");

// cons must hold in the same cycle as ante
`define UUC_ASSERT_IMPLY(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("uuc: implication violated");

// cons must hold in the cycle after ante
`define UUC_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("uuc: next-cycle implication violated");

`endif

// ===== design/uuc_pkg.sv =====
package uuc_pkg;

    localparam int unsigned RunMax    = 4;
    localparam int unsigned CountW    = $clog2(RunMax + 1);
    localparam int unsigned IdxW      = $clog2(RunMax);
    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QPtrW     = $clog2(QueueDepth);
    localparam int unsigned AddrWidth = 3;
    localparam int unsigned DataWidth = 32;

    localparam logic [AddrWidth-1:0] RegDirectionAddr = 3'd0;

    localparam logic DirEncode = 1'b0;
    localparam logic DirDecode = 1'b1;

    localparam logic [7:0] UuOffset   = 8'd32;
    localparam logic [5:0] UuOffset6  = 6'd32;
    localparam logic [7:0] UuNewline  = 8'd10;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD,
        PH_FOURTH
    } phase_t;

    // results caused by one input item, oldest in chars[0]
    typedef struct packed {
        logic [CountW-1:0]          count;
        logic [RunMax-1:0][7:0]     chars;
    } run_t;

    function automatic logic [7:0] enc_char(input logic [5:0] six);
        enc_char = {2'b00, six} + UuOffset;
    endfunction

endpackage

// ===== design/uuc_front.sv =====
`include "assert_macros.svh"

module uuc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               direction,
    input  logic               accept,
    input  logic [7:0]         data_value,
    input  logic               line_start,
    input  logic               line_end,
    input  logic [5:0]         line_byte_count,
    output logic               wr_en,
    output uuc_pkg::run_t      run
);
    import uuc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [5:0]  carried_reg, carried_next;
    logic [5:0]  rem_reg, rem_next;
    logic [5:0]  dec_v;

    assign dec_v = data_value[5:0] - UuOffset6;

    // next state
    always_comb
    begin
        phase_t     ph;
        logic [5:0] car;
        logic [5:0] rem;
        ph  = phase_reg;
        car = carried_reg;
        rem = rem_reg;
        if (direction == DirEncode)
        begin
            if (line_start)
            begin
                ph  = PH_FIRST;
                car = 6'd0;
                rem = line_byte_count;
            end
            case (ph)
                PH_FIRST:
                begin
                    car = {4'd0, data_value[1:0]};
                    ph  = PH_SECOND;
                end
                PH_SECOND:
                begin
                    car = {2'd0, data_value[3:0]};
                    ph  = PH_THIRD;
                end
                default:
                begin
                    car = 6'd0;
                    ph  = PH_FIRST;
                end
            endcase
            if (rem != 6'd0)
            begin
                rem = rem - 6'd1;
            end
        end
        else
        begin
            if (line_start)
            begin
                rem = dec_v;
                ph  = PH_FIRST;
                car = 6'd0;
            end
            else if (data_value != UuNewline && rem != 6'd0)
            begin
                case (ph)
                    PH_FIRST:
                    begin
                        car = dec_v;
                        ph  = PH_SECOND;
                    end
                    PH_SECOND:
                    begin
                        car = {2'd0, dec_v[3:0]};
                        ph  = PH_THIRD;
                        rem = rem - 6'd1;
                    end
                    PH_THIRD:
                    begin
                        car = {4'd0, dec_v[1:0]};
                        ph  = PH_FOURTH;
                        rem = rem - 6'd1;
                    end
                    default:
                    begin
                        car = 6'd0;
                        ph  = PH_FIRST;
                        rem = rem - 6'd1;
                    end
                endcase
            end
        end
        if (line_end)
        begin
            ph  = PH_FIRST;
            car = 6'd0;
            rem = 6'd0;
        end
        phase_next   = ph;
        carried_next = car;
        rem_next     = rem;
    end

    // results of the item
    always_comb
    begin
        phase_t            ph;
        phase_t            ph_after;
        logic [5:0]        car;
        logic [5:0]        car_after;
        logic [CountW-1:0] k;
        run = '0;
        k   = '0;
        ph  = line_start ? PH_FIRST : phase_reg;
        car = line_start ? 6'd0 : carried_reg;
        ph_after  = ph;
        car_after = car;
        if (direction == DirEncode)
        begin
            if (line_start)
            begin
                run.chars[0] = enc_char(line_byte_count);
                k = k + CountW'(1);
            end
            case (ph)
                PH_FIRST:
                begin
                    run.chars[k[IdxW-1:0]] = enc_char(data_value[7:2]);
                    k = k + CountW'(1);
                    ph_after  = PH_SECOND;
                    car_after = {4'd0, data_value[1:0]};
                end
                PH_SECOND:
                begin
                    run.chars[k[IdxW-1:0]] = enc_char({car[1:0], data_value[7:4]});
                    k = k + CountW'(1);
                    ph_after  = PH_THIRD;
                    car_after = {2'd0, data_value[3:0]};
                end
                default:
                begin
                    run.chars[k[IdxW-1:0]] = enc_char({car[3:0], data_value[7:6]});
                    k = k + CountW'(1);
                    run.chars[k[IdxW-1:0]] = enc_char(data_value[5:0]);
                    k = k + CountW'(1);
                    ph_after  = PH_FIRST;
                    car_after = 6'd0;
                end
            endcase
            if (line_end)
            begin
                // flush a partial group, then the newline
                case (ph_after)
                    PH_SECOND:
                    begin
                        run.chars[k[IdxW-1:0]] = enc_char({car_after[1:0], 4'd0});
                        k = k + CountW'(1);
                    end
                    PH_THIRD:
                    begin
                        run.chars[k[IdxW-1:0]] = enc_char({car_after[3:0], 2'd0});
                        k = k + CountW'(1);
                    end
                    default:
                    begin
                    end
                endcase
                run.chars[k[IdxW-1:0]] = UuNewline;
                k = k + CountW'(1);
            end
        end
        else
        begin
            if (!line_start && data_value != UuNewline && rem_reg != 6'd0)
            begin
                case (phase_reg)
                    PH_SECOND:
                    begin
                        run.chars[0] = {carried_reg, dec_v[5:4]};
                        k = CountW'(1);
                    end
                    PH_THIRD:
                    begin
                        run.chars[0] = {carried_reg[3:0], dec_v[5:2]};
                        k = CountW'(1);
                    end
                    PH_FOURTH:
                    begin
                        run.chars[0] = {carried_reg[1:0], dec_v};
                        k = CountW'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        run.count = k;
    end

    assign wr_en = accept && (run.count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_FIRST;
            carried_reg <= 6'd0;
            rem_reg     <= 6'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            carried_reg <= carried_next;
            rem_reg     <= rem_next;
        end
    end

    // decode gives at most one byte per character
    `UUC_ASSERT_IMPLY(a_dec_single, clk, rst_n, wr_en && direction == DirDecode, run.count == CountW'(1))
    // encode always gives a result, so it always writes the queue
    `UUC_ASSERT_IMPLY(a_enc_writes, clk, rst_n, accept && direction == DirEncode, wr_en)

endmodule

// ===== design/uuc_queue.sv =====
`include "assert_macros.svh"

module uuc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  uuc_pkg::run_t   wr_run,
    input  logic            rd_en,
    output uuc_pkg::run_t   head,
    output logic            full,
    output logic            empty
);
    import uuc_pkg::*;

    run_t              slot_reg [QueueDepth];
    logic [QPtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPtrW:0]    fill_reg, fill_next;

    assign full  = (fill_reg == (QPtrW+1)'(QueueDepth));
    assign empty = (fill_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + QPtrW'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + QPtrW'(1);
        end
        if (wr_en && !rd_en)
        begin
            fill_next = fill_reg + (QPtrW+1)'(1);
        end
        else if (rd_en && !wr_en)
        begin
            fill_next = fill_reg - (QPtrW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_run;
        end
    end

    `UUC_ASSERT_IMPLY(a_no_overflow, clk, rst_n, wr_en, !full)
    `UUC_ASSERT_IMPLY(a_no_underflow, clk, rst_n, rd_en, !empty)

endmodule

// ===== design/uuc_back.sv =====
`include "assert_macros.svh"

module uuc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  uuc_pkg::run_t   head,
    input  logic            q_empty,
    output logic            q_rd,
    input  logic            pop,
    output logic            empty,
    output logic [7:0]      out_value,
    output logic            last_of_run
);
    import uuc_pkg::*;

    logic [IdxW-1:0]  idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       value_reg;
    logic             last_reg;
    logic             load;
    logic             at_last;

    assign at_last = ((CountW'(idx_reg) + CountW'(1)) == head.count);
    // take the next character when the output stage is free or being drained
    assign load    = !q_empty && (!valid_reg || pop);
    assign q_rd    = load && at_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = at_last ? '0 : idx_reg + IdxW'(1);
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= head.chars[idx_reg];
            last_reg  <= at_last;
        end
    end

    assign empty       = !valid_reg;
    assign out_value   = value_reg;
    assign last_of_run = last_reg;

    // a waiting result is never dropped
    `UUC_ASSERT_NEXT(a_hold_result, clk, rst_n, valid_reg && !pop, valid_reg)
    // the run index never walks past the run length
    `UUC_ASSERT_IMPLY(a_idx_in_run, clk, rst_n, !q_empty, CountW'(idx_reg) < head.count)

endmodule

// ===== design/uuencode_line_codec.sv =====
// uuencode line codec. In encode mode (direction 0) each raw byte gives one or two characters
// (value+32), a line_start byte also gives the length character first, and a line_end byte
// flushes any partial group and adds a newline, so one byte gives up to four characters. In
// decode mode (direction 1) the first character of a line sets the byte count and each later
// character gives at most one byte. An item is taken in every cycle while the two-entry run
// queue has room; results leave one per cycle through the output register while pop is
// asserted. The first result of an item passes through the run queue and then the output
// register before it appears on the result ports. Write direction only while the codec is
// idle; writing it keeps line state.
module uuencode_line_codec (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [uuc_pkg::AddrWidth-1:0]       paddr,
    input  logic [uuc_pkg::DataWidth-1:0]       pwdata,
    output logic [uuc_pkg::DataWidth-1:0]       prdata,
    output logic                                pready,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          data_value,
    input  logic                                line_start,
    input  logic                                line_end,
    input  logic [5:0]                          line_byte_count,
    output logic                                empty,
    input  logic                                pop,
    output logic [7:0]                          out_value,
    output logic                                last_of_run
);
    import uuc_pkg::*;

    logic   direction_reg;
    logic   dir_sel;
    logic   accept;
    logic   wr_en;
    run_t   wr_run;
    run_t   head;
    logic   q_full;
    logic   q_empty;
    logic   q_rd;

    assign pready  = 1'b1;
    assign dir_sel = (paddr[AddrWidth-1:2] == RegDirectionAddr[AddrWidth-1:2]);
    assign prdata  = dir_sel ? {{(DataWidth-1){1'b0}}, direction_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DirEncode;
        end
        else if (psel && penable && pwrite && pready && dir_sel)
        begin
            direction_reg <= pwdata[0];
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    uuc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .direction       (direction_reg),
        .accept          (accept),
        .data_value      (data_value),
        .line_start      (line_start),
        .line_end        (line_end),
        .line_byte_count (line_byte_count),
        .wr_en           (wr_en),
        .run             (wr_run)
    );

    uuc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (wr_en),
        .wr_run (wr_run),
        .rd_en  (q_rd),
        .head   (head),
        .full   (q_full),
        .empty  (q_empty)
    );

    uuc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .q_rd        (q_rd),
        .pop         (pop),
        .empty       (empty),
        .out_value   (out_value),
        .last_of_run (last_of_run)
    );

endmodule
